>>> rtl/core/psq_pkg.sv
// Shared types and constants for the sorted-array priority queue.
// No dependencies; imported by every module of the block.
package psq_pkg;

  // Built depth and register layout
  localparam int unsigned DefDepth    = 16;
  localparam int unsigned CapW        = 5;
  localparam int unsigned AddrW       = 3;
  localparam int unsigned DataW       = 32;
  localparam logic [CapW-1:0] DefCapacity = 5'd16;

  // Register index (paddr[2])
  localparam logic RegCapacity = 1'b0;

  // Request kinds
  localparam logic [1:0] KindEnq  = 2'd0;
  localparam logic [1:0] KindDeq  = 2'd1;
  localparam logic [1:0] KindPeek = 2'd2;

  // Result status codes
  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatOverflow = 2'd1;
  localparam logic [1:0] StatEmpty    = 2'd2;

  // Controller states, one-hot
  typedef enum logic [1:0] {
    SIdle = 2'b01,
    SExec = 2'b10
  } psq_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture the request beat
    logic exec;  // apply it to the array and register the result
  } psq_cmd_t;

endpackage

>>> rtl/core/psq_regs.sv
// APB-style configuration register file: holds the capacity limit.
// Depends on psq_pkg.
module psq_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [psq_pkg::AddrW-1:0]    paddr,
  input  logic [psq_pkg::DataW-1:0]    pwdata,
  output logic [psq_pkg::DataW-1:0]    prdata,
  output logic                         pready,
  output logic [psq_pkg::CapW-1:0]     capacity_o
);
  import psq_pkg::*;

  logic [CapW-1:0] capacity_q, capacity_d;
  logic            wr_en;
  logic            hit;

  // Register decode: one word at byte address 0
  assign hit   = (paddr[2] == RegCapacity);
  assign wr_en = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    capacity_d = capacity_q;
    if (wr_en && hit) begin
      capacity_d = pwdata[CapW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= DefCapacity;
    end else begin
      capacity_q <= capacity_d;
    end
  end

  // Read back
  assign prdata     = hit ? {{(DataW-CapW){1'b0}}, capacity_q} : '0;
  assign capacity_o = capacity_q;

endmodule

>>> rtl/core/psq_ctrl.sv
// Request sequencer: accepts a beat, runs the execute state, returns to idle.
// Depends on psq_pkg.
module psq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output psq_pkg::psq_cmd_t cmd_o
);
  import psq_pkg::*;

  psq_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: begin
        if (start) begin
          state_d = SExec;
        end
      end
      SExec: begin
        state_d = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands and handshake
  assign busy       = (state_q != SIdle);
  assign cmd_o.load = start && (state_q == SIdle);
  assign cmd_o.exec = (state_q == SExec);

endmodule

>>> rtl/core/psq_datapath.sv
// Datapath: sorted shift-register array with per-slot compare, request
// capture and result registers. Depends on psq_pkg.
module psq_datapath #(
  parameter int unsigned Depth = psq_pkg::DefDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  psq_pkg::psq_cmd_t             cmd_i,
  input  logic [1:0]                    kind_i,
  input  logic signed [psq_pkg::DataW-1:0] value_i,
  input  logic [psq_pkg::CapW-1:0]      capacity_i,
  output logic signed [psq_pkg::DataW-1:0] result_value_o,
  output logic [1:0]                    status_o,
  output logic [psq_pkg::CapW-1:0]      fill_count_o,
  output logic                          done_o
);
  import psq_pkg::*;

  localparam int unsigned OccW = $clog2(Depth + 1);
  localparam int unsigned CmpW = (OccW > CapW) ? OccW : CapW;

  // Captured request beat
  logic [1:0]              kind_q;
  logic signed [DataW-1:0] value_q;

  // Array and fill count
  logic signed [DataW-1:0] entries_q [Depth];
  logic signed [DataW-1:0] entries_d [Depth];
  logic [OccW-1:0]         occ_q, occ_d;

  // Result registers
  logic signed [DataW-1:0] res_q, res_d;
  logic [1:0]              stat_q, stat_d;
  logic                    done_q;

  logic [Depth-1:0]        gt;
  logic                    full;
  logic                    empty;

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      value_q <= value_i;
    end
  end

  // Per-slot compare: live entry strictly greater than the new value
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      gt[i] = (OccW'(i) < occ_q) && (entries_q[i] > value_q);
    end
  end

  assign full  = (occ_q >= OccW'(Depth)) || (CmpW'(occ_q) >= CmpW'(capacity_i));
  assign empty = (occ_q == '0);

  // Operation on the array
  always_comb begin
    entries_d = entries_q;
    occ_d     = occ_q;
    res_d     = '0;
    stat_d    = StatOk;
    case (kind_q)
      KindEnq: begin
        if (full) begin
          stat_d = StatOverflow;
        end else begin
          // Larger entries move up one slot; value lands after equals
          if (gt[0] || (occ_q == '0)) begin
            entries_d[0] = value_q;
          end
          for (int i = 1; i < Depth; i++) begin
            if (gt[i] || (OccW'(i) == occ_q)) begin
              entries_d[i] = gt[i-1] ? entries_q[i-1] : value_q;
            end
          end
          occ_d = occ_q + 1'b1;
        end
      end
      KindDeq, KindPeek: begin
        if (empty) begin
          res_d  = '1;
          stat_d = StatEmpty;
        end else begin
          res_d = entries_q[0];
          if (kind_q == KindDeq) begin
            for (int i = 0; i < Depth - 1; i++) begin
              entries_d[i] = entries_q[i+1];
            end
            occ_d = occ_q - 1'b1;
          end
        end
      end
      default: begin
        stat_d = StatOk;
      end
    endcase
  end

  // Array storage, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      entries_q <= entries_d;
      res_q     <= res_d;
      stat_q    <= stat_d;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.exec;
      if (cmd_i.exec) begin
        occ_q <= occ_d;
      end
    end
  end

  assign result_value_o = res_q;
  assign status_o       = stat_q;
  assign fill_count_o   = CapW'(occ_q);
  assign done_o         = done_q;

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(Depth))
    else $error("fill count above built depth");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q >= OccW'(2) |-> entries_q[0] <= entries_q[1])
    else $error("head entries out of order");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (stat_q == StatEmpty) |-> (occ_q == '0) && (res_q == '1))
    else $error("empty status with entries held");

  a_done_follows_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |=> done_q && !cmd_i.exec)
    else $error("result strobe missing or execute longer than one cycle");
`endif

endmodule

>>> rtl/core/sorted_array_priority_queue.sv
// A request is captured at acceptance and applied to the array in the execute state;
// its result and the done_o strobe are then registered together.
// A new request is not taken while busy; busy is high in the execute state,
// where every slot of the shift-register array compares with the value at once.
// Results are shown for one cycle on done_o; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) empties the queue and sets capacity to 16.
module sorted_array_priority_queue #(
  parameter int unsigned Depth = psq_pkg::DefDepth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Request channel
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       kind_i,
  input  logic signed [psq_pkg::DataW-1:0] value_i,
  // Result channel
  output logic                             done_o,
  output logic signed [psq_pkg::DataW-1:0] result_value_o,
  output logic [1:0]                       status_o,
  output logic [psq_pkg::CapW-1:0]         fill_count_o,
  // Configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [psq_pkg::AddrW-1:0]        paddr,
  input  logic [psq_pkg::DataW-1:0]        pwdata,
  output logic [psq_pkg::DataW-1:0]        prdata,
  output logic                             pready
);
  import psq_pkg::*;

  psq_cmd_t        cmd;
  logic [CapW-1:0] capacity;

  psq_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .capacity_o (capacity)
  );

  psq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  psq_datapath #(
    .Depth (Depth)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .capacity_i     (capacity),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .fill_count_o   (fill_count_o),
    .done_o         (done_o)
  );

endmodule
